[rtl/b64d_pkg.sv]
// Shared types, character constants and the character-to-sextet map of the base64 decoder.
package b64d_pkg;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_DIGIT = 8'h30;  // '0'

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  localparam int GROUP_BITS = 24;

  // One finished group of four characters, as handed to the byte emitter.
  typedef struct packed {
    logic [GROUP_BITS-1:0] word;   // three bytes, first byte in the top bits
    logic [1:0]            count;  // bytes to emit, 0 only on a final group
    logic                  last;   // group closes the string
  } b64d_group_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] s;
    case (c) inside
      [8'h41:8'h5A]: s = 6'(c - CHAR_UPPER);
      [8'h61:8'h7A]: s = 6'(c - CHAR_LOWER) + SEXTET_LOWER;
      [8'h30:8'h39]: s = 6'(c - CHAR_DIGIT) + SEXTET_DIGIT;
      CHAR_PLUS:     s = SEXTET_PLUS;
      CHAR_SLASH:    s = SEXTET_SLASH;
      default:       s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/b64d_front.sv]
// Character intake: maps characters to sextets, gathers groups and works out the byte count.
module b64d_front import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  char_code,
  input  logic        end_of_text,
  output logic        group_push,
  output b64d_group_t group
);

  logic [17:0] sextet_store;
  logic [1:0]  group_position;
  logic [2:0]  pad_run;

  logic [2:0]  n;
  logic [23:0] acc;
  logic [2:0]  pads;
  logic [3:0]  pad_total;
  logic        group_done;

  always_comb begin
    n          = {1'b0, group_position} + 3'd1;
    acc        = {sextet_store, sextet_of(char_code)};
    pads       = (char_code == CHAR_PAD) ? pad_run + 3'd1 : 3'd0;
    group_done = end_of_text || (group_position == 2'd3);
    // A short final group counts its missing characters as padding.
    pad_total  = {1'b0, pads} + {1'b0, 3'd4 - n};

    case (group_position)
      2'd0:    group.word = {acc[5:0], 18'd0};
      2'd1:    group.word = {acc[11:0], 12'd0};
      2'd2:    group.word = {acc[17:0], 6'd0};
      default: group.word = acc;
    endcase

    if (!end_of_text) begin
      group.count = 2'd3;
    end else if (pad_total >= 4'd3) begin
      group.count = 2'd0;
    end else begin
      group.count = 2'(4'd3 - pad_total);
    end
    group.last = end_of_text;
    group_push = accept && group_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_store   <= '0;
      group_position <= '0;
      pad_run        <= '0;
    end else if (accept) begin
      if (group_done) begin
        sextet_store   <= '0;
        group_position <= '0;
        pad_run        <= '0;
      end else begin
        sextet_store   <= acc[17:0];
        group_position <= n[1:0];
        pad_run        <= pads;
      end
    end
  end

endmodule

[rtl/b64d_queue.sv]
// Short register queue of finished groups between the intake and the byte emitter.
module b64d_queue import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64d_group_t wr_data,
  output logic        full,
  input  logic        pop,
  output b64d_group_t rd_data,
  output logic        empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_group_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/b64d_back.sv]
// Byte emitter: walks each queued group one byte per cycle into the result register while it is empty or popped.
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  b64d_group_t head,
  input  logic        head_empty,
  output logic        head_pop,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  data_byte,
  output logic        no_data,
  output logic        final_byte
);

  logic       out_valid;
  logic [1:0] idx;

  logic       load;
  logic       take;
  logic       last_beat;
  logic [7:0] byte_sel;

  always_comb begin
    load      = !out_valid || pop;
    take      = load && !head_empty;
    last_beat = (head.count == 2'd0) || ((idx + 2'd1) == head.count);
    head_pop  = take && last_beat;
    case (idx)
      2'd0:    byte_sel = head.word[23:16];
      2'd1:    byte_sel = head.word[15:8];
      default: byte_sel = head.word[7:0];
    endcase
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !head_empty;
      if (take) begin
        idx <= last_beat ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      // A final group with no bytes still delivers one beat with the end mark.
      if (head.count == 2'd0) begin
        data_byte  <= 8'd0;
        no_data    <= 1'b1;
        final_byte <= 1'b1;
      end else begin
        data_byte  <= byte_sel;
        no_data    <= 1'b0;
        final_byte <= head.last && last_beat;
      end
    end
  end

endmodule

[rtl/base64_decoder.sv]
// Streaming base64 decoder. It takes one character per cycle whenever full is low and gives
// one result beat per cycle from a result register whenever the consumer pops. Each group of
// four characters becomes three byte beats; a final group with padding gives fewer, and a
// final group with no bytes gives one no_data beat carrying the end mark. The intake only
// stalls when QUEUE_DEPTH finished groups wait behind a stalled consumer, so the sustained
// input rate is one character per cycle as long as the consumer keeps up with the beats. A
// completed group is registered in the queue before its beats pass through the result register.
module base64_decoder import b64d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       no_data,
  output logic       final_byte
);

  logic        accept;
  logic        group_push;
  b64d_group_t group_in;
  b64d_group_t group_head;
  logic        q_empty;
  logic        q_pop;

  assign accept = push && !full;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .group_push  (group_push),
    .group       (group_in)
  );

  b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (group_push),
    .wr_data (group_in),
    .full    (full),
    .pop     (q_pop),
    .rd_data (group_head),
    .empty   (q_empty)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (group_head),
    .head_empty (q_empty),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .data_byte  (data_byte),
    .no_data    (no_data),
    .final_byte (final_byte)
  );

endmodule

[rtl/b64d_checker.sv]
// Port-level checks of the base64 decoder and the bind that attaches them.
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] data_byte,
  input logic       no_data,
  input logic       final_byte
);

  // Reset leaves nothing queued and nothing to deliver.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("decoder not cleared by reset");

  // A beat without a byte only ever closes a string.
  a_no_data_final: assert property (@(posedge clk) disable iff (rst)
    (!empty && no_data) |-> (final_byte && (data_byte == 8'd0)))
    else $error("no_data beat without end mark or with nonzero byte");

  // A waiting beat is not withdrawn.
  a_beat_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result beat dropped while stalled");

  // A waiting beat keeps its payload.
  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(data_byte) && $stable(no_data) && $stable(final_byte)))
    else $error("result payload changed while stalled");

endmodule

bind base64_decoder b64d_checker u_b64d_checker (.*);

[tb/base64_decoder_tb.sv]
// Self-checking testbench for the streaming base64 decoder with its own decode predictor.
`timescale 1ns / 1ps

module base64_decoder_tb;
  import b64d_pkg::*;

  localparam int          IDLE_PCT    = 18;
  localparam int          HOLD_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] code;
    logic       eot;
  } char_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       empty_mark;
    logic       fin;
  } byte_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic       end_of_text = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] data_byte;
  logic       no_data;
  logic       final_byte;

  char_beat_t  pending_chars[$];
  byte_beat_t  expected_bytes[$];
  int unsigned chars_queued = 0;
  int unsigned chars_taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          no_idle = 1'b0;
  bit          char_taken = 1'b0;

  // Predictor state: sextets of the open group, its length and the run of '='.
  logic [17:0] grp_store = '0;
  logic [1:0]  grp_count = '0;
  logic [2:0]  pad_count = '0;

  base64_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_code  (char_code),
    .end_of_text(end_of_text),
    .empty      (empty),
    .pop        (pop),
    .data_byte  (data_byte),
    .no_data    (no_data),
    .final_byte (final_byte)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [5:0] sextet_value(input logic [7:0] c);
    if (c >= CHAR_UPPER && c < CHAR_UPPER + 8'd26) return 6'(c - CHAR_UPPER);
    if (c >= CHAR_LOWER && c < CHAR_LOWER + 8'd26) return 6'(c - CHAR_LOWER) + SEXTET_LOWER;
    if (c >= CHAR_DIGIT && c < CHAR_DIGIT + 8'd10) return 6'(c - CHAR_DIGIT) + SEXTET_DIGIT;
    if (c == CHAR_PLUS) return SEXTET_PLUS;
    if (c == CHAR_SLASH) return SEXTET_SLASH;
    return 6'd0;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < SEXTET_LOWER) return CHAR_UPPER + 8'(v);
    if (v < SEXTET_DIGIT) return CHAR_LOWER + 8'(v - SEXTET_LOWER);
    if (v < SEXTET_PLUS) return CHAR_DIGIT + 8'(v - SEXTET_DIGIT);
    return (v == SEXTET_PLUS) ? CHAR_PLUS : CHAR_SLASH;
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic eot);
    logic [23:0] acc;
    logic [23:0] word;
    int          n;
    int          pads;
    int          pad_total;
    int          count;
    byte_beat_t  b;
    n = grp_count + 1;
    acc = {grp_store, sextet_value(c)};
    pads = (c == CHAR_PAD) ? pad_count + 1 : 0;
    if (!eot && n < 4) begin
      grp_store = acc[17:0];
      grp_count = 2'(n);
      pad_count = 3'(pads);
      return;
    end
    // A short group is left-aligned as if its missing sextets were zero.
    word = acc << (6 * (4 - n));
    if (!eot) begin
      count = 3;
    end else begin
      pad_total = pads + 4 - n;
      count = (pad_total >= 3) ? 0 : 3 - pad_total;
    end
    for (int i = 0; i < count; i++) begin
      b.data = word[23 - 8 * i -: 8];
      b.empty_mark = 1'b0;
      b.fin = eot && (i + 1 == count);
      expected_bytes.push_back(b);
    end
    if (eot && count == 0) begin
      b = '{data: 8'h00, empty_mark: 1'b1, fin: 1'b1};
      expected_bytes.push_back(b);
    end
    grp_store = '0;
    grp_count = '0;
    pad_count = '0;
  endtask

  task automatic add_char(input logic [7:0] c, input logic eot);
    pending_chars.push_back('{code: c, eot: eot});
    chars_queued++;
  endtask

  task automatic add_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], close && (i == s.len() - 1));
    end
  endtask

  // Mostly well-formed strings, some cut short, the rest raw noise.
  task automatic add_random_text();
    int kind;
    int tail;
    int pads;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      repeat ($urandom_range(0, 3)) begin
        repeat (4) add_char(b64_char(6'($urandom_range(0, 63))), 1'b0);
      end
      if (kind < 70) begin
        tail = 4;
        pads = $urandom_range(0, 2);
      end else begin
        tail = $urandom_range(1, 3);
        pads = $urandom_range(0, tail - 1);
      end
      for (int i = 0; i < tail; i++) begin
        add_char((i >= tail - pads) ? CHAR_PAD : b64_char(6'($urandom_range(0, 63))),
                 i == tail - 1);
      end
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        add_char(($urandom_range(0, 3) == 0) ? CHAR_PAD : 8'($urandom_range(0, 255)),
                 (i == len - 1) && ($urandom_range(0, 1) == 1));
      end
    end
  endtask

  // Sender: holds a beat until it is taken, then maybe idles.
  always @(negedge clk) begin
    char_beat_t item;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || char_taken) begin
      if (pending_chars.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        item = pending_chars.pop_front();
        push <= 1'b1;
        char_code <= item.code;
        end_of_text <= item.eot;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    byte_beat_t want;
    char_taken = !rst && push && !full;
    if (char_taken) begin
      chars_taken++;
      decode_char(char_code, end_of_text);
    end
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected beat data %h no_data %b final %b",
                   $realtime, data_byte, no_data, final_byte);
        end
      end else begin
        want = expected_bytes.pop_front();
        if (data_byte !== want.data || no_data !== want.empty_mark ||
            final_byte !== want.fin) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: expected data %h no_data %b final %b, got %h %b %b",
                     $realtime, want.data, want.empty_mark, want.fin,
                     data_byte, no_data, final_byte);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Full, padded, short and empty final groups, then '=' and invalid bytes mid-text.
    add_text("TWFu", 1'b1);
    add_text("TWE=", 1'b1);
    add_text("TQ==", 1'b1);
    add_text("A", 1'b1);
    add_text("+/9z=A=a", 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(8'h00, 1'b0);
    add_text("Z0", 1'b1);
    add_text("==", 1'b1);

    // The sender pauses here until the decoder has drained.
    while (chars_taken != chars_queued || expected_bytes.size() > 0) @(posedge clk);

    no_idle = 1'b1;
    while (chars_queued < 125) add_random_text();
    while (chars_taken != chars_queued) @(posedge clk);
    no_idle = 1'b0;

    hold_req = 1'b1;
    while (chars_queued < 375) add_random_text();

    while (chars_taken != chars_queued) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    errors += expected_bytes.size();
    if (errors == 0) begin
      $display("base64_decoder: match");
    end else begin
      $display("base64_decoder: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder.sv
rtl/b64d_checker.sv
tb/base64_decoder_tb.sv
